// ===== design/cstm_pkg.sv =====
// Shared types and constants of the CAN signal timeout and range monitor.
`timescale 1ns / 1ps
package cstm_pkg;

  localparam int unsigned SlotCount = 6;
  localparam int unsigned CfgWidth  = 48;
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [1:0] {
    ActFrame = 2'd0,
    ActCheck = 2'd1,
    ActClear = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    RsnNone     = 3'd0,
    RsnSpeedHi  = 3'd1,
    RsnRpmHi    = 3'd2,
    RsnTempHi   = 3'd3,
    RsnBattLo   = 3'd4,
    RsnBattHi   = 3'd5
  } reason_e;

  localparam logic [CfgIdxW-1:0] RegIdLow     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIdHigh    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegToLow     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegToHigh    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpeedLim  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTempLim   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRpmLim    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBattWin   = 3'd7;

  localparam int unsigned SlotSpeed = 0;
  localparam int unsigned SlotRpm   = 1;
  localparam int unsigned SlotTemp  = 3;
  localparam int unsigned SlotBatt  = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [10:0] frame_id;
    logic        ecu_fault_in;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [31:0] tick;
  } in_t;

  typedef struct packed {
    logic        ecu_fault;
    logic        range_fault;
    logic [2:0]  range_reason;
    logic        timeout_fault;
    logic [5:0]  timeout_mask;
  } out_t;

  typedef struct packed {
    logic [32:0] id_low;
    logic [32:0] id_high;
    logic [47:0] to_low;
    logic [47:0] to_high;
    logic [7:0]  speed_lim;
    logic [7:0]  temp_lim;
    logic [15:0] rpm_lim;
    logic [31:0] batt_win;
  } cfg_t;

  typedef struct packed {
    logic       clear;
    logic [5:0] stamp;
  } upd_t;

endpackage

// ===== design/cstm_eval.sv =====
// Per-transaction slot match, range check and timeout evaluation.
`timescale 1ns / 1ps
module cstm_eval (
  input  cstm_pkg::in_t  item_i,
  input  cstm_pkg::cfg_t cfg_i,
  input  logic [5:0]     seen_i,
  input  logic [31:0]    last_i [6],
  output cstm_pkg::out_t res_o,
  output cstm_pkg::upd_t upd_o
);
  import cstm_pkg::*;

  logic [10:0] slot_id  [SlotCount];
  logic [15:0] slot_to  [SlotCount];
  logic [5:0]  id_hit;
  logic [5:0]  first_hit;
  logic [5:0]  expired;
  logic [15:0] word;
  logic [15:0] batt_lo;
  logic [15:0] batt_hi;
  logic [31:0] age      [SlotCount];
  reason_e     reason;

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      slot_id[s]   = cfg_i.id_low[s*11 +: 11];
      slot_id[s+3] = cfg_i.id_high[s*11 +: 11];
      slot_to[s]   = cfg_i.to_low[s*16 +: 16];
      slot_to[s+3] = cfg_i.to_high[s*16 +: 16];
    end
  end

  always_comb begin
    for (int s = 0; s < SlotCount; s++) begin
      id_hit[s]  = (slot_id[s] == item_i.frame_id);
      age[s]     = item_i.tick - last_i[s];
      expired[s] = seen_i[s] && (age[s] > {16'd0, slot_to[s]});
    end
    first_hit = id_hit & (~id_hit + 6'd1);
  end

  assign word    = {item_i.byte0, item_i.byte1};
  assign batt_lo = cfg_i.batt_win[15:0];
  assign batt_hi = cfg_i.batt_win[31:16];

  always_comb begin
    reason = RsnNone;
    if (id_hit[SlotSpeed]) begin
      if (item_i.byte0 > cfg_i.speed_lim) reason = RsnSpeedHi;
    end else if (id_hit[SlotRpm]) begin
      if (word > cfg_i.rpm_lim) reason = RsnRpmHi;
    end else if (id_hit[SlotTemp]) begin
      if (item_i.byte0 > cfg_i.temp_lim) reason = RsnTempHi;
    end else if (id_hit[SlotBatt]) begin
      if (word < batt_lo) reason = RsnBattLo;
      else if (word > batt_hi) reason = RsnBattHi;
    end
  end

  always_comb begin
    res_o = '0;
    upd_o = '0;
    case (item_i.action)
      ActFrame: begin
        res_o.ecu_fault    = item_i.ecu_fault_in;
        res_o.range_reason = reason;
        res_o.range_fault  = (reason != RsnNone);
        upd_o.stamp        = first_hit;
      end
      ActCheck: begin
        res_o.timeout_mask  = expired;
        res_o.timeout_fault = |expired;
      end
      ActClear: begin
        upd_o.clear = 1'b1;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

// ===== design/can_signal_timeout_and_range_monitor.sv =====
// Top level of the CAN signal timeout and range monitor.
// Path: a transaction accepted into the input register is evaluated from there, and its
// result is captured in the result register, from which it is presented.
// Throughput: one transaction per cycle; the input register and the result register
// decouple the two channels, so input stalls only when both are full and the result stalls.
// Reset: clears slot state, valid bits and loads register defaults.
`timescale 1ns / 1ps
module can_signal_timeout_and_range_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cstm_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cstm_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [cstm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cstm_pkg::CfgWidth-1:0]   cfg_wdata_i
);
  import cstm_pkg::*;

  cfg_t        cfg_q;
  in_t         in_q;
  logic        in_valid_q;
  out_t        out_q;
  logic        out_valid_q;
  logic [5:0]  seen_q;
  logic [31:0] last_q [SlotCount];
  out_t        res;
  upd_t        upd;
  logic        advance;
  logic        in_acc;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  cstm_eval u_eval (
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .seen_i (seen_q),
    .last_i (last_q),
    .res_o  (res),
    .upd_o  (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.id_low    <= '0;
      cfg_q.id_high   <= '0;
      cfg_q.to_low    <= 48'h03E8_03E8_03E8;
      cfg_q.to_high   <= 48'h03E8_03E8_03E8;
      cfg_q.speed_lim <= 8'hFF;
      cfg_q.temp_lim  <= 8'hFF;
      cfg_q.rpm_lim   <= 16'hFFFF;
      cfg_q.batt_win  <= 32'hFFFF_0000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIdLow:    cfg_q.id_low    <= cfg_wdata_i[32:0];
        RegIdHigh:   cfg_q.id_high   <= cfg_wdata_i[32:0];
        RegToLow:    cfg_q.to_low    <= cfg_wdata_i;
        RegToHigh:   cfg_q.to_high   <= cfg_wdata_i;
        RegSpeedLim: cfg_q.speed_lim <= cfg_wdata_i[7:0];
        RegTempLim:  cfg_q.temp_lim  <= cfg_wdata_i[7:0];
        RegRpmLim:   cfg_q.rpm_lim   <= cfg_wdata_i[15:0];
        RegBattWin:  cfg_q.batt_win  <= cfg_wdata_i[31:0];
        default:     cfg_q           <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int s = 0; s < SlotCount; s++) begin
        last_q[s] <= '0;
      end
    end else if (advance) begin
      if (upd.clear) begin
        seen_q <= '0;
        for (int s = 0; s < SlotCount; s++) begin
          last_q[s] <= '0;
        end
      end else begin
        for (int s = 0; s < SlotCount; s++) begin
          if (upd.stamp[s]) begin
            seen_q[s] <= 1'b1;
            last_q[s] <= in_q.tick;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_q.action == ActClear)) |=> (seen_q == '0))
    else $error("slots still seen after clear");

  a_stamp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> $onehot0(upd.stamp))
    else $error("more than one slot stamped");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room available");

  a_fault_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.timeout_fault == (out_q.timeout_mask != '0)) &&
                     (out_q.range_fault == (out_q.range_reason != RsnNone))))
    else $error("fault flag disagrees with its detail");
`endif

endmodule

// ===== tb/can_signal_timeout_and_range_monitor_test.sv =====
// Testbench of the CAN signal timeout and range monitor: flag prediction, stimulus and checks.
`timescale 1ns / 1ps
module can_signal_timeout_and_range_monitor_test;
  import cstm_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam int CfgRegs = 8;
  localparam int CfgRandom = 0;
  localparam int CfgAllOnes = 1;
  localparam int CfgAllZero = 2;
  localparam int CfgDuplicate = 3;
  localparam int RandomPhases = 10;
  localparam int PhaseItems = 125;

  class flag_scoreboard;
    cfg_t        regs;
    logic [31:0] stamp_tick [SlotCount];
    logic        seen [SlotCount];
    out_t        expected_flags [$];
    int          failures;

    function new();
      regs.id_low    = '0;
      regs.id_high   = '0;
      regs.to_low    = 48'h03E8_03E8_03E8;
      regs.to_high   = 48'h03E8_03E8_03E8;
      regs.speed_lim = 8'hFF;
      regs.temp_lim  = 8'hFF;
      regs.rpm_lim   = 16'hFFFF;
      regs.batt_win  = 32'hFFFF_0000;
      clear_slots();
      failures = 0;
    endfunction

    function void clear_slots();
      for (int s = 0; s < SlotCount; s++) begin
        stamp_tick[s] = '0;
        seen[s] = 1'b0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgWidth-1:0] data);
      case (idx)
        RegIdLow:    regs.id_low    = data[32:0];
        RegIdHigh:   regs.id_high   = data[32:0];
        RegToLow:    regs.to_low    = data[47:0];
        RegToHigh:   regs.to_high   = data[47:0];
        RegSpeedLim: regs.speed_lim = data[7:0];
        RegTempLim:  regs.temp_lim  = data[7:0];
        RegRpmLim:   regs.rpm_lim   = data[15:0];
        RegBattWin:  regs.batt_win  = data[31:0];
        default: ;
      endcase
    endfunction

    function logic [10:0] slot_id(int unsigned s);
      if (s < 3) return regs.id_low[s*11 +: 11];
      return regs.id_high[(s-3)*11 +: 11];
    endfunction

    function logic [15:0] slot_timeout(int unsigned s);
      if (s < 3) return regs.to_low[s*16 +: 16];
      return regs.to_high[(s-3)*16 +: 16];
    endfunction

    function out_t predict_flags(in_t it);
      out_t        res;
      logic        stamped;
      logic [15:0] word;
      logic [31:0] age;
      res = '0;
      stamped = 1'b0;
      word = {it.byte0, it.byte1};
      case (it.action)
        ActFrame: begin
          for (int s = 0; s < SlotCount; s++) begin
            if (!stamped && slot_id(s) == it.frame_id) begin
              stamp_tick[s] = it.tick;
              seen[s] = 1'b1;
              stamped = 1'b1;
            end
          end
          res.ecu_fault = it.ecu_fault_in;
          if (it.frame_id == slot_id(SlotSpeed)) begin
            if (it.byte0 > regs.speed_lim) res.range_reason = RsnSpeedHi;
          end else if (it.frame_id == slot_id(SlotRpm)) begin
            if (word > regs.rpm_lim) res.range_reason = RsnRpmHi;
          end else if (it.frame_id == slot_id(SlotTemp)) begin
            if (it.byte0 > regs.temp_lim) res.range_reason = RsnTempHi;
          end else if (it.frame_id == slot_id(SlotBatt)) begin
            if (word < regs.batt_win[15:0]) res.range_reason = RsnBattLo;
            else if (word > regs.batt_win[31:16]) res.range_reason = RsnBattHi;
          end
          res.range_fault = (res.range_reason != RsnNone);
        end
        ActCheck: begin
          for (int s = 0; s < SlotCount; s++) begin
            age = it.tick - stamp_tick[s];
            if (seen[s] && age > {16'd0, slot_timeout(s)}) res.timeout_mask[s] = 1'b1;
          end
          res.timeout_fault = (res.timeout_mask != '0);
        end
        ActClear: clear_slots();
        default: ;
      endcase
      return res;
    endfunction

    function void note_input(in_t it);
      expected_flags.push_back(predict_flags(it));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_flags.size() == 0) begin
        if (failures < 10) $display("unexpected result: %p", got);
        failures++;
        return;
      end
      want = expected_flags.pop_front();
      if (got.ecu_fault !== want.ecu_fault || got.range_fault !== want.range_fault ||
          got.range_reason !== want.range_reason || got.timeout_fault !== want.timeout_fault ||
          got.timeout_mask !== want.timeout_mask) begin
        if (failures < 10) begin
          $display("mismatch: expected ecu=%0b rf=%0b rsn=%0d tf=%0b mask=%02h",
                   want.ecu_fault, want.range_fault, want.range_reason,
                   want.timeout_fault, want.timeout_mask);
          $display("          actual   ecu=%0b rf=%0b rsn=%0d tf=%0b mask=%02h",
                   got.ecu_fault, got.range_fault, got.range_reason,
                   got.timeout_fault, got.timeout_mask);
        end
        failures++;
      end
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i = '0;
  logic [CfgWidth-1:0]   cfg_wdata_i = '0;

  flag_scoreboard        sb = new();
  logic [CfgWidth-1:0]   reg_vals [CfgRegs];
  logic [31:0]           tick_now = '0;
  int                    stall_mode = 0;
  int                    stall_left = 0;

  can_signal_timeout_and_range_monitor i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  task automatic send_item(input in_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic send_fields(input logic [1:0] act, input logic [10:0] id, input logic ecu,
                             input logic [7:0] b0, input logic [7:0] b1,
                             input logic [31:0] tick);
    in_t it;
    it.action = act;
    it.frame_id = id;
    it.ecu_fault_in = ecu;
    it.byte0 = b0;
    it.byte1 = b1;
    it.tick = tick;
    send_item(it);
  endtask

  task automatic idle_for(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs();
    logic [CfgIdxW-1:0] idx;
    for (int r = 0; r < CfgRegs; r++) begin
      idx = r[CfgIdxW-1:0];
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= reg_vals[r];
      @(posedge clk_i);
      sb.write_reg(idx, reg_vals[r]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input int kind);
    logic [10:0] ids [SlotCount];
    logic [15:0] tos [SlotCount];
    logic [10:0] pool0;
    logic [10:0] pool1;
    logic [15:0] bmin;
    logic [15:0] bmax;
    logic [63:0] noise;
    pool0 = 11'($urandom_range(0, 2047));
    pool1 = 11'($urandom_range(0, 2047));
    for (int s = 0; s < SlotCount; s++) begin
      if (kind == CfgDuplicate) ids[s] = $urandom_range(0, 1) ? pool0 : pool1;
      else ids[s] = 11'($urandom_range(0, 2047));
      if ($urandom_range(0, 9) == 0) tos[s] = 16'($urandom_range(0, 65535));
      else tos[s] = 16'($urandom_range(0, 400));
    end
    if (kind == CfgDuplicate) begin
      bmin = 16'($urandom_range(30000, 65535));
      bmax = 16'($urandom_range(0, 29999));
    end else begin
      bmin = 16'($urandom_range(0, 40000));
      bmax = bmin + 16'($urandom_range(0, 25000));
    end
    for (int r = 0; r < CfgRegs; r++) begin
      noise = {$urandom, $urandom};
      reg_vals[r] = noise[CfgWidth-1:0];
    end
    noise = {$urandom, $urandom};
    reg_vals[RegIdLow][33:0] = {noise[0], ids[2], ids[1], ids[0]};
    reg_vals[RegIdHigh][33:0] = {noise[1], ids[5], ids[4], ids[3]};
    reg_vals[RegToLow] = {tos[2], tos[1], tos[0]};
    reg_vals[RegToHigh] = {tos[5], tos[4], tos[3]};
    reg_vals[RegBattWin][31:0] = {bmax, bmin};
    if (kind == CfgAllOnes || kind == CfgAllZero) begin
      for (int r = 0; r < CfgRegs; r++) reg_vals[r] = (kind == CfgAllOnes) ? '1 : '0;
    end
    program_regs();
  endtask

  function automatic in_t random_item();
    in_t         it;
    int          roll;
    logic [15:0] word;
    logic [63:0] noise;
    roll = $urandom_range(0, 99);
    if (roll < 3) tick_now = $urandom;
    else if (roll < 5) tick_now = tick_now - $urandom_range(0, 500);
    else tick_now = tick_now + $urandom_range(0, 60);
    noise = {$urandom, $urandom};
    it = noise[$bits(in_t)-1:0];
    it.tick = tick_now;
    roll = $urandom_range(0, 99);
    if (roll < 58) it.action = ActFrame;
    else if (roll < 91) it.action = ActCheck;
    else if (roll < 95) it.action = ActClear;
    else it.action = ActUnused;
    if (it.action == ActFrame) begin
      if ($urandom_range(0, 99) < 85) it.frame_id = sb.slot_id($urandom_range(0, 5));
      it.ecu_fault_in = ($urandom_range(0, 4) == 0);
      word = 16'($urandom_range(0, 2)) - 16'd1;
      case ($urandom_range(0, 5))
        1: it.byte0 = sb.regs.speed_lim + word[7:0];
        2: it.byte0 = sb.regs.temp_lim + word[7:0];
        3: {it.byte0, it.byte1} = sb.regs.rpm_lim + word;
        4: {it.byte0, it.byte1} = sb.regs.batt_win[15:0] + word;
        5: {it.byte0, it.byte1} = sb.regs.batt_win[31:16] + word;
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic run_random(input int count, input logic bursty);
    int burst;
    burst = 0;
    repeat (count) begin
      if (bursty && burst == 0) begin
        burst = $urandom_range(1, 24);
        idle_for($urandom_range(1, 8));
      end
      send_item(random_item());
      if (burst > 0) burst--;
    end
  endtask

  initial begin
    int kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults: every ID is zero, timeouts of 1000
    send_fields(ActFrame, 11'h000, 1'b1, 8'hFF, 8'hFF, 32'h0000_0000);
    send_fields(ActFrame, 11'h7FF, 1'b0, 8'h00, 8'h00, 32'hFFFF_FFFF);
    send_fields(ActCheck, 11'h7FF, 1'b1, 8'hFF, 8'hFF, 32'd1000);
    send_fields(ActCheck, 11'h000, 1'b0, 8'h00, 8'h00, 32'd1001);
    send_fields(ActUnused, 11'h7FF, 1'b1, 8'hFF, 8'hFF, 32'd5);
    send_fields(ActClear, 11'h7FF, 1'b1, 8'hFF, 8'hFF, 32'd2000);
    send_fields(ActCheck, 11'h000, 1'b0, 8'h00, 8'h00, 32'hFFFF_FFFF);
    settle();

    reg_vals[RegIdLow] = {14'h3FFF, 1'b1, 11'h102, 11'h101, 11'h100};
    reg_vals[RegIdHigh] = {14'h0, 1'b0, 11'h105, 11'h104, 11'h103};
    reg_vals[RegToLow] = {16'hFFFF, 16'd10, 16'd10};
    reg_vals[RegToHigh] = {16'd10, 16'd10, 16'd10};
    reg_vals[RegSpeedLim] = 48'hFFFF_FFFF_FF64;
    reg_vals[RegTempLim] = 48'd90;
    reg_vals[RegRpmLim] = 48'h0000_0000_1234;
    reg_vals[RegBattWin] = 48'hABCD_4000_3000;
    program_regs();
    send_fields(ActFrame, 11'h100, 1'b0, 8'd101, 8'h00, 32'hFFFF_FFF0);
    send_fields(ActFrame, 11'h100, 1'b1, 8'd100, 8'hFF, 32'hFFFF_FFF1);
    send_fields(ActFrame, 11'h101, 1'b0, 8'h12, 8'h35, 32'hFFFF_FFF2);
    send_fields(ActFrame, 11'h101, 1'b0, 8'h12, 8'h34, 32'hFFFF_FFF3);
    send_fields(ActFrame, 11'h103, 1'b0, 8'd91, 8'h00, 32'hFFFF_FFF4);
    send_fields(ActFrame, 11'h104, 1'b0, 8'h2F, 8'hFF, 32'hFFFF_FFF5);
    send_fields(ActFrame, 11'h104, 1'b0, 8'h40, 8'h01, 32'hFFFF_FFF6);
    send_fields(ActFrame, 11'h104, 1'b0, 8'h30, 8'h00, 32'hFFFF_FFF7);
    send_fields(ActFrame, 11'h102, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFF8);
    send_fields(ActFrame, 11'h105, 1'b0, 8'hFF, 8'hFF, 32'hFFFF_FFF9);
    send_fields(ActFrame, 11'h555, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFA);
    send_fields(ActCheck, 11'h100, 1'b0, 8'h00, 8'h00, 32'h0000_0005);
    settle();

    // duplicate IDs and an inverted battery window
    reg_vals[RegIdLow] = {15'h0, 1'b0, 11'h2AA, 11'h2AA, 11'h2AA};
    reg_vals[RegIdHigh] = {15'h0, 1'b1, 11'h2AA, 11'h155, 11'h2AA};
    reg_vals[RegSpeedLim] = 48'h80;
    reg_vals[RegBattWin] = 48'h0000_1000_8000;
    program_regs();
    send_fields(ActFrame, 11'h2AA, 1'b0, 8'hFF, 8'h00, 32'd100);
    send_fields(ActCheck, 11'h000, 1'b0, 8'h00, 8'h00, 32'h8000_0000);
    send_fields(ActFrame, 11'h155, 1'b0, 8'h08, 8'h00, 32'd200);
    send_fields(ActFrame, 11'h155, 1'b0, 8'h90, 8'h00, 32'd300);
    settle();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        1, 7: kind = CfgDuplicate;
        2: kind = CfgAllOnes;
        5: kind = CfgAllZero;
        default: kind = CfgRandom;
      endcase
      configure(kind);
      case ($urandom_range(0, 2))
        0: tick_now = $urandom;
        1: tick_now = 32'hFFFF_FF00 + $urandom_range(0, 255);
        default: tick_now = $urandom_range(0, 1000);
      endcase
      run_random(PhaseItems, (p % 3) != 2);
      settle();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== can_signal_timeout_and_range_monitor.f =====
design/cstm_pkg.sv
design/cstm_eval.sv
design/can_signal_timeout_and_range_monitor.sv
tb/can_signal_timeout_and_range_monitor_test.sv
